// ===== sv/lpfvdt_pkg.sv =====
// shared constants for the variable time step low-pass filter
// no dependencies

package lpfvdt_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned DenW      = CfgW + 1;
  localparam int unsigned MulAW     = CfgW + 1;
  localparam int unsigned MulBW     = DataW + 1;
  localparam int unsigned AccW      = MulAW + MulBW;
  localparam int unsigned DivSteps  = AccW;
  localparam int unsigned DivCntW   = $clog2(DivSteps + 1);

  localparam logic [CfgIdxW-1:0] CfgTimeConst = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMaxGap    = CfgIdxW'(1);

  localparam logic [CfgW-1:0] MaxGapReset = CfgW'(300);

  typedef struct packed {
    logic                 start;
    logic [AccW-1:0]      dividend;
    logic [DenW-1:0]      divisor;
  } div_req_t;

endpackage

// ===== sv/lpfvdt_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on lpfvdt_pkg

module lpfvdt_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lpfvdt_pkg::div_req_t        req_i,
  output logic                        done_o,
  output logic [lpfvdt_pkg::DataW-1:0] quotient_o
);

  logic [lpfvdt_pkg::DenW-1:0]    rem_q;
  logic [lpfvdt_pkg::DenW-1:0]    div_q;
  logic [lpfvdt_pkg::AccW-1:0]    quo_q;
  logic [lpfvdt_pkg::DivCntW-1:0] cnt_q;
  logic                           done_q;

  logic [lpfvdt_pkg::DenW:0]      shifted;
  logic [lpfvdt_pkg::DenW+1:0]    diff;

  assign shifted = {rem_q, quo_q[lpfvdt_pkg::AccW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= lpfvdt_pkg::DivCntW'(lpfvdt_pkg::DivSteps);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == lpfvdt_pkg::DivCntW'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - lpfvdt_pkg::DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      div_q <= req_i.divisor;
      quo_q <= req_i.dividend;
    end else if (cnt_q != '0) begin
      if (diff[lpfvdt_pkg::DenW+1]) begin
        rem_q <= shifted[lpfvdt_pkg::DenW-1:0];
      end else begin
        rem_q <= diff[lpfvdt_pkg::DenW-1:0];
      end
      quo_q <= {quo_q[lpfvdt_pkg::AccW-2:0], ~diff[lpfvdt_pkg::DenW+1]};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[lpfvdt_pkg::DataW-1:0];

endmodule

// ===== sv/lowpass_filter_variable_dt_core.sv =====
// first-order low-pass filter with variable time step, top level
// depends on lpfvdt_pkg and lpfvdt_div
//
// input channel: sample_i (signed Q16.16) and time_ms_i, taken when in_valid_i is
// high and in_stall_o is low. output channel: filtered_o, taken when out_valid_o is
// high and out_stall_i is low. exactly one output transaction per input transaction.
// y = (T*last + d*x) / (T + d), rounded to nearest, where d is the wrapped tick delta.
// one item at a time: in_stall_o stays high from acceptance until the result has been
// loaded into the output register.
// path: a sample passes straight to StOut when the gap is too large or T + d is zero;
// otherwise it runs StMulA and StMulB on the shared 17x33 multiplier, StPrep to form the
// rounded magnitude, StDiv in the bit-serial divider until its done flag, then the load.
// a stalled receiver holds the result in the output register; a finished next
// result waits until that register is free.
// reset: time constant 0, gap limit 300 ms, stored output and stored tick 0.

module lowpass_filter_variable_dt_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lpfvdt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [lpfvdt_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [lpfvdt_pkg::DataW-1:0] sample_i,
  input  logic [lpfvdt_pkg::DataW-1:0]      time_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [lpfvdt_pkg::DataW-1:0] filtered_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMulA,
    StMulB,
    StPrep,
    StDiv,
    StOut
  } state_e;

  state_e state_q;

  logic [lpfvdt_pkg::CfgW-1:0]  tconst_q;
  logic [lpfvdt_pkg::CfgW-1:0]  max_gap_q;
  logic [lpfvdt_pkg::DataW-1:0] last_out_q;
  logic [lpfvdt_pkg::DataW-1:0] last_time_q;
  logic [lpfvdt_pkg::DataW-1:0] x_q;
  logic [lpfvdt_pkg::CfgW-1:0]  d_q;
  logic [lpfvdt_pkg::DenW-1:0]  den_q;
  logic signed [lpfvdt_pkg::AccW-1:0] acc_q;
  logic                         neg_q;
  logic [lpfvdt_pkg::DataW-1:0] y_q;
  logic [lpfvdt_pkg::DataW-1:0] out_q;
  logic                         out_valid_q;

  logic                         in_acc;
  logic                         out_free;
  logic [lpfvdt_pkg::DataW-1:0] delta;
  logic [lpfvdt_pkg::DenW-1:0]  den_new;
  logic                         bypass;
  logic signed [lpfvdt_pkg::MulAW-1:0] mul_a;
  logic signed [lpfvdt_pkg::MulBW-1:0] mul_b;
  logic signed [lpfvdt_pkg::AccW-1:0]  product;
  logic [lpfvdt_pkg::AccW-1:0]  mag;
  lpfvdt_pkg::div_req_t         div_req;
  logic                         div_done;
  logic [lpfvdt_pkg::DataW-1:0] quotient;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign delta   = time_ms_i - last_time_q;
  assign den_new = {1'b0, tconst_q} + {1'b0, delta[lpfvdt_pkg::CfgW-1:0]};
  assign bypass  = (delta > {{(lpfvdt_pkg::DataW-lpfvdt_pkg::CfgW){1'b0}}, max_gap_q})
                || (den_new == '0);

  // shared multiplier, operands picked by the sequencer
  always_comb begin
    if (state_q == StMulA) begin
      mul_a = $signed({1'b0, tconst_q});
      mul_b = $signed({last_out_q[lpfvdt_pkg::DataW-1], last_out_q});
    end else begin
      mul_a = $signed({1'b0, d_q});
      mul_b = $signed({x_q[lpfvdt_pkg::DataW-1], x_q});
    end
  end

  assign product = mul_a * mul_b;

  // rounded magnitude: |num| + den/2
  assign mag = (acc_q[lpfvdt_pkg::AccW-1] ? lpfvdt_pkg::AccW'(-acc_q) : acc_q)
             + {{(lpfvdt_pkg::AccW-lpfvdt_pkg::DenW+1){1'b0}},
                den_q[lpfvdt_pkg::DenW-1:1]};

  assign div_req.start    = (state_q == StPrep);
  assign div_req.dividend = mag;
  assign div_req.divisor  = den_q;

  lpfvdt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tconst_q    <= '0;
      max_gap_q   <= lpfvdt_pkg::MaxGapReset;
      last_out_q  <= '0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
      state_q     <= StIdle;
    end else begin
      if (cfg_we_i && cfg_idx_i == lpfvdt_pkg::CfgTimeConst) begin
        tconst_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == lpfvdt_pkg::CfgMaxGap) begin
        max_gap_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            last_time_q <= time_ms_i;
            state_q     <= bypass ? StOut : StMulA;
          end
        end
        StMulA: state_q <= StMulB;
        StMulB: state_q <= StPrep;
        StPrep: state_q <= StDiv;
        StDiv: begin
          if (div_done) begin
            state_q <= StOut;
          end
        end
        StOut: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            last_out_q  <= y_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q   <= sample_i;
      d_q   <= delta[lpfvdt_pkg::CfgW-1:0];
      den_q <= den_new;
      y_q   <= sample_i;
    end
    if (state_q == StMulA) begin
      acc_q <= product;
    end
    if (state_q == StMulB) begin
      acc_q <= acc_q + product;
    end
    if (state_q == StPrep) begin
      neg_q <= acc_q[lpfvdt_pkg::AccW-1];
    end
    if (state_q == StDiv && div_done) begin
      y_q <= neg_q ? -quotient : quotient;
    end
    if (state_q == StOut && out_free) begin
      out_q <= y_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_q;

endmodule
